// ----- sv/qbc_pkg.sv -----
// Shared types, constants and saturation helpers for the quantized bilinear
// contraction block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qbc_pkg;

    // Field and register widths
    localparam int WORD_W      = 32;
    localparam int PROD_W      = 2 * WORD_W;
    localparam int CFG_W       = 2 * WORD_W;
    localparam int CFG_INDEX_W = 4;

    // Lane arrangement and scaling
    localparam int NUM_LANES     = 8;
    localparam int NUM_VEC       = 4;
    localparam int LANE_SHIFT    = 28;
    localparam int LANE_SUM_W    = PROD_W + 1;
    localparam int LANE_SHIFTED_W = LANE_SUM_W - LANE_SHIFT;

    // Pipeline depth: three lane stages and two merge stages
    localparam int LANE_STAGES  = 3;
    localparam int MERGE_STAGES = 2;
    localparam int LATENCY      = LANE_STAGES + MERGE_STAGES;

    // Number of configuration registers, one weight pair per lane
    localparam logic [CFG_INDEX_W-1:0] NUM_WEIGHT_REGS = CFG_INDEX_W'(NUM_LANES);

    typedef logic signed [WORD_W-1:0]         word_t;
    typedef logic signed [PROD_W-1:0]         prod_t;
    typedef logic signed [LANE_SUM_W-1:0]     lane_sum_t;
    typedef logic signed [LANE_SHIFTED_W-1:0] lane_shifted_t;
    typedef logic        [CFG_W-1:0]          cfg_word_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // Clamp a full-width product to the signed word range
    function automatic word_t sat_prod(input prod_t v);
        logic upper_same;
        upper_same = (&v[PROD_W-1:WORD_W-1]) | ~(|v[PROD_W-1:WORD_W-1]);
        if (upper_same)
            return v[WORD_W-1:0];
        else if (v[PROD_W-1])
            return WORD_MIN;
        else
            return WORD_MAX;
    endfunction

    // Clamp a shifted lane value to the signed word range
    function automatic word_t sat_lane(input lane_shifted_t v);
        logic upper_same;
        upper_same = (&v[LANE_SHIFTED_W-1:WORD_W-1]) | ~(|v[LANE_SHIFTED_W-1:WORD_W-1]);
        if (upper_same)
            return v[WORD_W-1:0];
        else if (v[LANE_SHIFTED_W-1])
            return WORD_MIN;
        else
            return WORD_MAX;
    endfunction

endpackage

`default_nettype wire

// ----- sv/qbc_lane.sv -----
// One contraction lane: two outer-product entries, their weighted products,
// exact sum, floor shift and clamp. Depends on qbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qbc_lane
    import qbc_pkg::*;
(
    input  wire logic  clk,
    input  wire word_t xa,
    input  wire word_t xb,
    input  wire word_t yj,
    input  wire word_t wa,
    input  wire word_t wb,
    output word_t      lane_val
);

    word_t         pa_reg;
    word_t         pb_reg;
    prod_t         wpa_reg;
    prod_t         wpb_reg;
    word_t         lane_reg;

    prod_t         pa_full;
    prod_t         pb_full;
    prod_t         wpa_next;
    prod_t         wpb_next;
    lane_sum_t     lane_sum;
    lane_shifted_t lane_shifted;

    // Stage 1: outer-product entries, clamped to a word
    assign pa_full = xa * yj;
    assign pb_full = xb * yj;

    // Stage 2: weight the clamped entries
    assign wpa_next = pa_reg * wa;
    assign wpb_next = pb_reg * wb;

    // Stage 3: exact sum, arithmetic shift (floor), clamp
    assign lane_sum     = {wpa_reg[PROD_W-1], wpa_reg} + {wpb_reg[PROD_W-1], wpb_reg};
    assign lane_shifted = lane_sum[LANE_SUM_W-1:LANE_SHIFT];

    always_ff @(posedge clk)
    begin
        pa_reg   <= sat_prod(pa_full);
        pb_reg   <= sat_prod(pb_full);
        wpa_reg  <= wpa_next;
        wpb_reg  <= wpb_next;
        lane_reg <= sat_lane(lane_shifted);
    end

    assign lane_val = lane_reg;

endmodule

`default_nettype wire

// ----- sv/qbc_merge.sv -----
// Two-stage adder tree that wraps the eight lane values into one word.
// Depends on qbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qbc_merge
    import qbc_pkg::*;
(
    input  wire logic  clk,
    input  wire word_t lane_vals [NUM_LANES],
    output word_t      sum
);

    localparam int HALF = NUM_LANES / 2;

    word_t lo_reg;
    word_t hi_reg;
    word_t sum_reg;
    word_t lo_next;
    word_t hi_next;

    // Add each half of the lanes, wrapping at word width
    always_comb
    begin
        lo_next = '0;
        hi_next = '0;
        for (int i = 0; i < HALF; i++)
        begin
            lo_next = lo_next + lane_vals[i];
            hi_next = hi_next + lane_vals[i + HALF];
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        sum_reg <= lo_reg + hi_reg;
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

// ----- sv/quantized_bilinear_contraction.sv -----
// Top level of the quantized 4x4 bilinear contraction: weight registers,
// eight lanes, merge tree and valid pipeline. Depends on qbc_pkg, qbc_lane, qbc_merge.
//
//   channel   | handshake             | payload
//   ----------+-----------------------+--------------------------
//   input     | start, busy           | x0..x3, y0..y3
//   result    | done (one-cycle)      | result
//   config    | cfg_we                | cfg_index, cfg_data
//
// One item is taken every cycle; busy stays low. Between taking an item and
// its result lie three lane stages (entry multiply, weight multiply,
// sum/shift/clamp) and two adder-tree stages. The result is shown
// for one cycle with done high; the receiver cannot stall the block.
// Reset clears the weights and the valid pipeline; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module quantized_bilinear_contraction
    import qbc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire word_t                  x0,
    input  wire word_t                  x1,
    input  wire word_t                  x2,
    input  wire word_t                  x3,
    input  wire word_t                  y0,
    input  wire word_t                  y1,
    input  wire word_t                  y2,
    input  wire word_t                  y3,
    output logic                        done,
    output word_t                       result,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire cfg_word_t              cfg_data
);

    localparam int LANE_IDX_W = $clog2(NUM_LANES);

    cfg_word_t          weight_reg [NUM_LANES];
    logic [LATENCY-1:0] valid_reg;
    logic [LATENCY-1:0] valid_next;
    logic               accept;

    word_t x_vec    [NUM_VEC];
    word_t y_vec    [NUM_VEC];
    word_t lane_val [NUM_LANES];

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    assign x_vec[0] = x0;
    assign x_vec[1] = x1;
    assign x_vec[2] = x2;
    assign x_vec[3] = x3;
    assign y_vec[0] = y0;
    assign y_vec[1] = y1;
    assign y_vec[2] = y2;
    assign y_vec[3] = y3;

    // Write a weight pair; drop writes beyond the register list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LANES; i++)
                weight_reg[i] <= '0;
        end
        else if (cfg_we && (cfg_index < NUM_WEIGHT_REGS))
        begin
            weight_reg[cfg_index[LANE_IDX_W-1:0]] <= cfg_data;
        end
    end

    // Advance the valid marks alongside the data
    assign valid_next = {valid_reg[LATENCY-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // Lane k takes entries k and k+8 of the outer product
    for (genvar k = 0; k < NUM_LANES; k++)
    begin : g_lane
        qbc_lane u_lane (
            .clk      (clk),
            .xa       (x_vec[k / NUM_VEC]),
            .xb       (x_vec[k / NUM_VEC + 2]),
            .yj       (y_vec[k % NUM_VEC]),
            .wa       (word_t'(weight_reg[k][WORD_W-1:0])),
            .wb       (word_t'(weight_reg[k][CFG_W-1:WORD_W])),
            .lane_val (lane_val[k])
        );
    end

    qbc_merge u_merge (
        .clk       (clk),
        .lane_vals (lane_val),
        .sum       (result)
    );

    assign done = valid_reg[LATENCY-1];

    // Every result traces back to an item taken earlier
    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result strobe without a matching item");

    // Every taken item later yields a result
    a_item_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("item taken but no result delivered");

    // The first and last weight pairs change only on a configuration write
    a_weights_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> $stable(weight_reg[0]) && $stable(weight_reg[NUM_LANES-1]))
        else $error("weights changed without a write");

endmodule

`default_nettype wire

// ----- tb/contraction_checker.sv -----
// Checker for the quantized bilinear contraction: mirrors the weight registers,
// predicts one sum per accepted item and compares it with each done strobe.
// Depends on qbc_pkg.
`timescale 1ns / 1ps

module contraction_checker
    import qbc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  word_t                  x0,
    input  word_t                  x1,
    input  word_t                  x2,
    input  word_t                  x3,
    input  word_t                  y0,
    input  word_t                  y1,
    input  word_t                  y2,
    input  word_t                  y3,
    input  logic                   done,
    input  word_t                  result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  cfg_word_t              cfg_data,
    output int                     mismatches,
    output int                     outstanding
);

    localparam int SLOT_W = $clog2(NUM_LANES);

    cfg_word_t weight_pairs [NUM_LANES];
    word_t     expected_sums [$];

    initial mismatches = 0;

    task automatic report_mismatch(input string what);
        begin
            $display("[%0t] %s", $time, what);
            mismatches++;
        end
    endtask

    // Clamp an exact value to the signed word range
    function automatic word_t clamp_word(input logic signed [LANE_SUM_W-1:0] v);
        begin
            if (v > WORD_MAX)
                return WORD_MAX;
            else if (v < WORD_MIN)
                return WORD_MIN;
            else
                return v[WORD_W-1:0];
        end
    endfunction

    // Outer product, weighted lane pairs, floor shift, clamp, wrapped total
    function automatic word_t contract_vectors(input logic [4*WORD_W-1:0] xs,
                                               input logic [4*WORD_W-1:0] ys);
        word_t                         entry [16];
        word_t                         w_lo;
        word_t                         w_hi;
        logic signed [LANE_SUM_W-1:0]  exact;
        logic [WORD_W-1:0]             total;
        int                            i;
        int                            j;
        int                            k;
        begin
            total = '0;
            for (i = 0; i < NUM_VEC; i++)
            begin
                for (j = 0; j < NUM_VEC; j++)
                begin
                    exact = $signed(xs[WORD_W*i +: WORD_W]) * $signed(ys[WORD_W*j +: WORD_W]);
                    entry[NUM_VEC*i + j] = clamp_word(exact);
                end
            end
            for (k = 0; k < NUM_LANES; k++)
            begin
                w_lo  = weight_pairs[k][WORD_W-1:0];
                w_hi  = weight_pairs[k][CFG_W-1:WORD_W];
                exact = entry[k] * w_lo + entry[k+NUM_LANES] * w_hi;
                exact = exact >>> LANE_SHIFT;
                total = total + clamp_word(exact);
            end
            return word_t'(total);
        end
    endfunction

    // Track register writes, predict on accept, compare on done
    always @(posedge clk or negedge rst_n)
    begin : watch
        word_t want;
        int    k;
        if (!rst_n)
        begin
            for (k = 0; k < NUM_LANES; k++)
                weight_pairs[k] = '0;
            expected_sums.delete();
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_sums.size() == 0)
                    report_mismatch($sformatf("result %0d with no item waiting", result));
                else
                begin
                    want = expected_sums.pop_front();
                    if (result !== want)
                        report_mismatch($sformatf("result: got %0d, expected %0d",
                                                  result, want));
                end
            end
            if (start && !busy)
                expected_sums.push_back(contract_vectors({x3, x2, x1, x0},
                                                         {y3, y2, y1, y0}));
            // Writes beyond the register list are dropped
            if (cfg_we && cfg_index < NUM_WEIGHT_REGS)
                weight_pairs[cfg_index[SLOT_W-1:0]] = cfg_data;
            outstanding <= expected_sums.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the testbench for quantized_bilinear_contraction: clock, reset,
// weight programming, directed and random items, verdict. Depends on qbc_pkg
// and contraction_checker.
`timescale 1ns / 1ps

module testbench;
    import qbc_pkg::*;

    typedef enum {WEIGHTS_UNIT, WEIGHTS_LOWEST, WEIGHTS_HIGHEST, WEIGHTS_MIXED} weight_style_t;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 240;
    localparam int GAP_CAP         = 20;
    localparam int DRAIN_LIMIT     = 200;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   start     = 1'b0;
    word_t                  x0        = '0;
    word_t                  x1        = '0;
    word_t                  x2        = '0;
    word_t                  x3        = '0;
    word_t                  y0        = '0;
    word_t                  y1        = '0;
    word_t                  y2        = '0;
    word_t                  y3        = '0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    cfg_word_t              cfg_data  = '0;
    logic                   busy;
    logic                   done;
    word_t                  result;
    int                     mismatches;
    int                     outstanding;

    always #1 clk = ~clk;

    quantized_bilinear_contraction uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .x0        (x0),
        .x1        (x1),
        .x2        (x2),
        .x3        (x3),
        .y0        (y0),
        .y1        (y1),
        .y2        (y2),
        .y3        (y3),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    contraction_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .x0          (x0),
        .x1          (x1),
        .x2          (x2),
        .x3          (x3),
        .y0          (y0),
        .y1          (y1),
        .y2          (y2),
        .y3          (y3),
        .done        (done),
        .result      (result),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Vector element: extremes, near zero, small, or any pattern
    function automatic word_t pick_operand();
        begin
            case ($urandom_range(7))
                0:       return WORD_MIN;
                1:       return WORD_MAX;
                2:       return '0;
                3:       return word_t'($urandom_range(2)) - word_t'(1);
                4:       return word_t'($urandom_range(131071)) - word_t'(65536);
                default: return word_t'($urandom);
            endcase
        end
    endfunction

    // Weight half: extremes, plus or minus unity in Q28, small, zero, or any pattern
    function automatic word_t pick_weight();
        begin
            case ($urandom_range(6))
                0:       return WORD_MIN;
                1:       return WORD_MAX;
                2:       return word_t'($urandom_range(131071)) - word_t'(65536);
                3:       return $urandom_range(1) ? word_t'(32'h1000_0000)
                                                  : word_t'(32'hF000_0000);
                4:       return '0;
                default: return word_t'($urandom);
            endcase
        end
    endfunction

    // Hold one register write for an edge; the caller lowers the enable
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input cfg_word_t data);
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge clk);
        end
    endtask

    // Program all eight weight pairs, then one write beyond the list
    task automatic load_weights(input weight_style_t style);
        cfg_word_t pair;
        int        k;
        begin
            for (k = 0; k < NUM_LANES; k++)
            begin
                case (style)
                    WEIGHTS_UNIT:    pair = {2{32'h1000_0000}};
                    WEIGHTS_LOWEST:  pair = {WORD_MIN, WORD_MIN};
                    WEIGHTS_HIGHEST: pair = {WORD_MAX, WORD_MAX};
                    default:         pair = {pick_weight(), pick_weight()};
                endcase
                write_register(CFG_INDEX_W'(k), pair);
            end
            write_register(NUM_WEIGHT_REGS + CFG_INDEX_W'($urandom_range(7)),
                           {$urandom, $urandom});
            cfg_we <= 1'b0;
        end
    endtask

    // Idle for a random stretch, then hold the item until it is taken
    task automatic offer_vectors(input logic [4*WORD_W-1:0] xs, input logic [4*WORD_W-1:0] ys,
                                 input int idle_pct);
        int gap;
        begin
            gap = 0;
            while (gap < GAP_CAP && $urandom_range(99) < idle_pct)
                gap++;
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            start            <= 1'b1;
            {x3, x2, x1, x0} <= xs;
            {y3, y2, y1, y0} <= ys;
            @(posedge clk);
            while (busy)
                @(posedge clk);
        end
    endtask

    // Stop sending and wait until every expected sum has come out or the drain limit is hit
    task automatic settle();
        int guard;
        begin
            start <= 1'b0;
            guard = 0;
            do
            begin
                @(posedge clk);
                guard++;
            end
            while (outstanding != 0 && guard < DRAIN_LIMIT);
            repeat (LATENCY + 2) @(posedge clk);
        end
    endtask

    // Extreme vectors, including every entry overflowing, and one random item
    task automatic run_directed();
        begin
            offer_vectors('0, '0, 0);
            offer_vectors({4{WORD_MAX}}, {4{WORD_MAX}}, 0);
            offer_vectors({4{WORD_MIN}}, {4{WORD_MIN}}, 0);
            offer_vectors({4{WORD_MIN}}, {4{WORD_MAX}}, 0);
            offer_vectors({32'h0000_0001, 32'hFFFF_FFFF, WORD_MAX, WORD_MIN},
                          {32'h0000_0000, WORD_MAX, 32'hFFFF_FFFF, WORD_MIN}, 0);
            offer_vectors({$urandom, $urandom, $urandom, $urandom},
                          {$urandom, $urandom, $urandom, $urandom}, 0);
            settle();
        end
    endtask

    initial
    begin : stimulus
        int phase;
        int n;
        int idle_pct;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items under reset weights, unit weights and the extreme weight sets
        run_directed();
        load_weights(WEIGHTS_UNIT);
        run_directed();
        load_weights(WEIGHTS_LOWEST);
        run_directed();
        load_weights(WEIGHTS_HIGHEST);
        run_directed();

        // Random items under fresh weights, cycling the sender's idle rate
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 66;
                default: idle_pct = 24;
            endcase
            load_weights(WEIGHTS_MIXED);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n == ITEMS_PER_PHASE / 2)
                    settle();
                offer_vectors({pick_operand(), pick_operand(), pick_operand(), pick_operand()},
                              {pick_operand(), pick_operand(), pick_operand(), pick_operand()},
                              idle_pct);
            end
            settle();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("PASS quantized_bilinear_contraction");
        else
            $display("FAIL quantized_bilinear_contraction");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("FAIL quantized_bilinear_contraction");
        $finish;
    end

endmodule
